[rtl/evlog_pkg.sv]
// ----------------------------------------------------------------------------
// evlog_pkg
// Shared types for the event trace log: request and response payloads,
// stored entry layouts and the action codes.
// ----------------------------------------------------------------------------
`default_nettype none

package evlog_pkg;

  localparam int KIND_W   = 4;
  localparam int DETAIL_W = 16;
  localparam int TIME_W   = 32;
  localparam int INDEX_W  = 6;
  localparam int TOTAL_W  = 32;
  localparam int FILL_W   = 7;

  typedef enum logic [1:0] {
    ACT_EMIT  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_LOG   = 2'd1,
    SRC_CACHE = 2'd2
  } src_e;

  typedef struct packed {
    action_e                     action;
    logic [KIND_W-1:0]           event_kind;
    logic signed [DETAIL_W-1:0]  event_detail;
    logic [TIME_W-1:0]           time_stamp;
    logic [INDEX_W-1:0]          log_index;
  } req_t;

  typedef struct packed {
    logic                        found;
    logic [KIND_W-1:0]           entry_kind;
    logic [TIME_W-1:0]           out_time;
    logic signed [DETAIL_W-1:0]  entry_detail;
    logic [TOTAL_W-1:0]          emit_total;
    logic [FILL_W-1:0]           fill_count;
  } rsp_t;

  typedef struct packed {
    logic [KIND_W-1:0]           kind;
    logic [TIME_W-1:0]           stamp;
    logic signed [DETAIL_W-1:0]  detail;
  } log_entry_t;

  typedef struct packed {
    logic [TIME_W-1:0]           stamp;
    logic signed [DETAIL_W-1:0]  detail;
  } cache_entry_t;

endpackage

`default_nettype wire

[rtl/evlog_if.sv]
// ----------------------------------------------------------------------------
// evlog request / response channels
// Valid/ready channels carrying one request or one response payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface evlog_req_if;
  logic              valid;
  logic              ready;
  evlog_pkg::req_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface evlog_rsp_if;
  logic              valid;
  logic              ready;
  evlog_pkg::rsp_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/evlog_ram.sv]
// ----------------------------------------------------------------------------
// evlog_ram
// Generic single-port RAM: each enabled access is a write or a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module evlog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/event_ring_log_with_kind_cache.sv]
// A request passes the RAM read register and then the response register;
// a stalled response holds both.
// Throughput: one request per cycle unless the response side stalls; each request
// makes at most one access to each of the log RAM and the kind cache RAM.
// Reset clears the write pointer, fill count, emit counter and the kind
// cache valid bits; log RAM contents are not cleared, no clearing pass.
// ----------------------------------------------------------------------------
// event_ring_log_with_kind_cache
// Circular event trace log with per-kind latest timestamp/detail cache.
// ----------------------------------------------------------------------------
`default_nettype none

module event_ring_log_with_kind_cache #(
  parameter int LOG_DEPTH    = 64,
  parameter int CACHED_KINDS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  evlog_req_if.sink   req_i,
  evlog_rsp_if.source rsp_o
);

  localparam int LA_W  = $clog2(LOG_DEPTH);
  localparam int CNT_W = $clog2(LOG_DEPTH + 1);
  localparam int KA_W  = (CACHED_KINDS > 1) ? $clog2(CACHED_KINDS) : 1;
  localparam int KC_W  = evlog_pkg::KIND_W + 1;
  localparam int CMP_W = (CNT_W > evlog_pkg::INDEX_W) ? CNT_W : evlog_pkg::INDEX_W;
  localparam int SUM_W = ((LA_W > CMP_W) ? LA_W : CMP_W) + 2;
  localparam int LOG_W   = $bits(evlog_pkg::log_entry_t);
  localparam int CACHE_W = $bits(evlog_pkg::cache_entry_t);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LOG_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(LOG_DEPTH);

  evlog_pkg::req_t           req;
  logic                      acc, s1_adv, in_rdy;
  logic                      is_emit, is_read, is_query, kind_hit, idx_hit;
  logic [LA_W-1:0]           wslot_q, wslot_d, rd_slot, log_addr;
  logic [CNT_W-1:0]          cnt_q, cnt_d, gap;
  logic [31:0]               total_q, total_d;
  logic [CACHED_KINDS-1:0]   kval_q, kval_d;
  logic [KA_W-1:0]           kaddr;
  logic [SUM_W-1:0]          sum;
  logic                      log_en, cache_en, kv_hit;
  evlog_pkg::log_entry_t     log_wdata, log_rdata;
  evlog_pkg::cache_entry_t   cache_wdata, cache_rdata;
  evlog_pkg::src_e           src;

  logic                      s1_v_q, s1_v_d;
  evlog_pkg::src_e           s1_src_q;
  logic                      s1_kv_q;
  logic [31:0]               s1_total_q;
  logic [evlog_pkg::FILL_W-1:0] s1_fill_q;

  logic                      out_v_q, out_v_d;
  evlog_pkg::rsp_t           out_q, rsp_d;

  assign req      = req_i.data;
  assign s1_adv   = !out_v_q || rsp_o.ready;
  assign in_rdy   = !s1_v_q || s1_adv;
  assign acc      = req_i.valid && in_rdy;
  assign req_i.ready = in_rdy;

  assign is_emit  = (req.action == evlog_pkg::ACT_EMIT);
  assign is_read  = (req.action == evlog_pkg::ACT_READ);
  assign is_query = (req.action == evlog_pkg::ACT_QUERY);
  assign kind_hit = KC_W'(req.event_kind) < KC_W'(CACHED_KINDS);
  assign kaddr    = KA_W'(req.event_kind);
  assign idx_hit  = CMP_W'(req.log_index) < CMP_W'(cnt_q);
  assign kv_hit   = kind_hit ? kval_q[kaddr] : 1'b0;

  // oldest entry sits at wslot - count (mod depth)
  assign gap      = DEPTH_C - cnt_q;
  assign sum      = SUM_W'(wslot_q) + SUM_W'(gap) + SUM_W'(req.log_index);
  assign rd_slot  = (sum >= DEPTH_S) ? LA_W'(sum - DEPTH_S) : LA_W'(sum);
  assign log_addr = is_emit ? wslot_q : rd_slot;
  assign log_en   = acc && (is_emit || (is_read && idx_hit));
  assign cache_en = acc && kind_hit && (is_emit || is_query);

  assign log_wdata.kind     = req.event_kind;
  assign log_wdata.stamp    = req.time_stamp;
  assign log_wdata.detail   = req.event_detail;
  assign cache_wdata.stamp  = req.time_stamp;
  assign cache_wdata.detail = req.event_detail;

  evlog_ram #(.WIDTH(LOG_W), .DEPTH(LOG_DEPTH)) u_log_ram (
    .clk_i   (clk_i),
    .en_i    (log_en),
    .we_i    (is_emit),
    .addr_i  (log_addr),
    .wdata_i (log_wdata),
    .rdata_o (log_rdata)
  );

  evlog_ram #(.WIDTH(CACHE_W), .DEPTH(CACHED_KINDS)) u_cache_ram (
    .clk_i   (clk_i),
    .en_i    (cache_en),
    .we_i    (is_emit),
    .addr_i  (kaddr),
    .wdata_i (cache_wdata),
    .rdata_o (cache_rdata)
  );

  always_comb begin
    wslot_d = wslot_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    kval_d  = kval_q;
    if (acc && is_emit) begin
      wslot_d = (wslot_q == LA_W'(LOG_DEPTH - 1)) ? '0 : wslot_q + 1'b1;
      if (cnt_q != DEPTH_C) begin
        cnt_d = cnt_q + 1'b1;
      end
      total_d = total_q + 32'd1;
      if (kind_hit) begin
        kval_d[kaddr] = 1'b1;
      end
    end
  end

  always_comb begin
    case (req.action)
      evlog_pkg::ACT_READ:  src = idx_hit  ? evlog_pkg::SRC_LOG   : evlog_pkg::SRC_NONE;
      evlog_pkg::ACT_QUERY: src = kind_hit ? evlog_pkg::SRC_CACHE : evlog_pkg::SRC_NONE;
      default:              src = evlog_pkg::SRC_NONE;
    endcase
  end

  always_comb begin
    s1_v_d = s1_v_q;
    if (acc) begin
      s1_v_d = 1'b1;
    end else if (s1_adv) begin
      s1_v_d = 1'b0;
    end
  end

  always_comb begin
    rsp_d            = '0;
    rsp_d.emit_total = s1_total_q;
    rsp_d.fill_count = s1_fill_q;
    case (s1_src_q)
      evlog_pkg::SRC_LOG: begin
        rsp_d.found        = 1'b1;
        rsp_d.entry_kind   = log_rdata.kind;
        rsp_d.out_time     = log_rdata.stamp;
        rsp_d.entry_detail = log_rdata.detail;
      end
      evlog_pkg::SRC_CACHE: begin
        rsp_d.found = 1'b1;
        if (s1_kv_q) begin
          rsp_d.out_time     = cache_rdata.stamp;
          rsp_d.entry_detail = cache_rdata.detail;
        end
      end
      default: begin
        rsp_d.found = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_v_d = out_v_q;
    if (s1_v_q && s1_adv) begin
      out_v_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wslot_q <= '0;
      cnt_q   <= '0;
      total_q <= '0;
      kval_q  <= '0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      wslot_q <= wslot_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      kval_q  <= kval_d;
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_src_q   <= src;
      s1_kv_q    <= kv_hit;
      s1_total_q <= total_d;
      s1_fill_q  <= evlog_pkg::FILL_W'(cnt_d);
    end
    if (s1_v_q && s1_adv) begin
      out_q <= rsp_d;
    end
  end

  assign rsp_o.valid = out_v_q;
  assign rsp_o.data  = out_q;

endmodule

`default_nettype wire

[rtl/evlog_chk.sv]
// ----------------------------------------------------------------------------
// evlog_chk
// Response-side checks for the event trace log, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module evlog_chk #(
  parameter int LOG_DEPTH = 64
) (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            rsp_valid_i,
  input wire logic            rsp_ready_i,
  input wire evlog_pkg::rsp_t rsp_i
);

  logic        hs;
  logic        seen_q;
  logic [31:0] last_total_q;

  assign hs = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      last_total_q <= '0;
    end else if (hs) begin
      seen_q       <= 1'b1;
      last_total_q <= rsp_i.emit_total;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hs |-> (int'(rsp_i.fill_count) <= LOG_DEPTH))
    else $error("fill count above log depth");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hs && !rsp_i.found) |->
      (rsp_i.entry_kind == '0 && rsp_i.out_time == '0 && rsp_i.entry_detail == '0))
    else $error("miss response carries data");

  a_kind_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hs && rsp_i.entry_kind != '0) |-> rsp_i.found)
    else $error("entry kind without found");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hs && seen_q) |->
      (rsp_i.emit_total == last_total_q || rsp_i.emit_total == last_total_q + 32'd1))
    else $error("emit total jumped between responses");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_i)))
    else $error("stalled response changed");

endmodule

bind event_ring_log_with_kind_cache evlog_chk #(.LOG_DEPTH(LOG_DEPTH)) u_evlog_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_i       (rsp_o.data)
);

`default_nettype wire

[test/tb_event_ring_log_with_kind_cache.sv]
// ----------------------------------------------------------------------------
// tb_event_ring_log_with_kind_cache
// Self-checking bench for the event trace log. A directed table covers the
// reset state, field extremes, reads past the fill count and uncached kinds.
// After that, about 1650 random requests run against a shadow trace log and
// kind cache. The bench stalls both channels at random and holds the response
// side off once to back the log up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_event_ring_log_with_kind_cache;
  import evlog_pkg::*;

  localparam int LOG_DEPTH      = 64;
  localparam int CACHED_KINDS   = 8;
  localparam int RANDOM_ITEMS   = 1650;
  localparam int FLOOD_ITEMS    = 150;
  localparam int DRAIN_AT       = 900;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam action_e ACT_UNUSED = action_e'(2'd3);
  localparam rsp_t    NO_RSP     = '0;

  typedef enum {RX_STEADY, RX_COIN, RX_THIRD, RX_SPARSE} rx_mode_e;

  typedef struct {
    logic typed;
    rsp_t rsp;
  } fixed_rsp_t;

  typedef struct {
    req_t       req;
    fixed_rsp_t fixed;
  } directed_row_t;

  logic clk;
  logic rst_n;

  evlog_req_if req_if ();
  evlog_rsp_if rsp_if ();

  event_ring_log_with_kind_cache #(
    .LOG_DEPTH    (LOG_DEPTH),
    .CACHED_KINDS (CACHED_KINDS)
  ) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow trace log and kind cache
  log_entry_t   shadow_log [LOG_DEPTH];
  cache_entry_t shadow_latest [CACHED_KINDS] = '{default: '0};
  int unsigned  shadow_slot = 0;
  int unsigned  shadow_held = 0;
  logic [31:0]  shadow_emits = '0;

  rsp_t         awaited_rsp [$];
  fixed_rsp_t   fixed_rsp [$];
  int           fail_count = 0;
  int           idle_cycles = 0;
  bit           flood_start = 0;
  bit           hold_done = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic rsp_t trace_step(req_t r);
    rsp_t        o;
    int unsigned slot;
    o = '0;
    case (r.action)
      ACT_EMIT: begin
        shadow_log[shadow_slot] = '{kind: r.event_kind, stamp: r.time_stamp,
                                    detail: r.event_detail};
        shadow_slot = (shadow_slot + 1) % LOG_DEPTH;
        if (shadow_held < LOG_DEPTH) shadow_held++;
        if (r.event_kind < CACHED_KINDS) begin
          shadow_latest[r.event_kind] = '{stamp: r.time_stamp, detail: r.event_detail};
        end
        shadow_emits = shadow_emits + 32'd1;
      end
      ACT_READ: begin
        if (r.log_index < shadow_held) begin
          slot = (shadow_slot + LOG_DEPTH - shadow_held + r.log_index) % LOG_DEPTH;
          o.found        = 1'b1;
          o.entry_kind   = shadow_log[slot].kind;
          o.out_time     = shadow_log[slot].stamp;
          o.entry_detail = shadow_log[slot].detail;
        end
      end
      ACT_QUERY: begin
        if (r.event_kind < CACHED_KINDS) begin
          o.found        = 1'b1;
          o.out_time     = shadow_latest[r.event_kind].stamp;
          o.entry_detail = shadow_latest[r.event_kind].detail;
        end
      end
      default: ;
    endcase
    o.emit_total = shadow_emits;
    o.fill_count = FILL_W'(shadow_held);
    return o;
  endfunction

  function automatic rsp_t mk_rsp(logic found, logic [3:0] kind, logic [31:0] stamp,
                                  logic [15:0] detail, logic [31:0] total,
                                  logic [6:0] fill);
    rsp_t o;
    o.found        = found;
    o.entry_kind   = kind;
    o.out_time     = stamp;
    o.entry_detail = detail;
    o.emit_total   = total;
    o.fill_count   = fill;
    return o;
  endfunction

  function automatic directed_row_t vec(action_e a, logic [3:0] kind, logic [15:0] detail,
                                        logic [31:0] stamp, logic [5:0] idx,
                                        logic typed, rsp_t rsp);
    directed_row_t row;
    row.req.action       = a;
    row.req.event_kind   = kind;
    row.req.event_detail = detail;
    row.req.time_stamp   = stamp;
    row.req.log_index    = idx;
    row.fixed.typed      = typed;
    row.fixed.rsp        = rsp;
    return row;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    r.event_kind = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0:       r.event_detail = 16'hFFFF;
      1:       r.event_detail = 16'h8000;
      2:       r.event_detail = 16'h7FFF;
      default: r.event_detail = 16'($urandom);
    endcase
    r.time_stamp = $urandom;
    r.log_index  = 6'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.action = ACT_EMIT;
    end else if (pick < 75) begin
      r.action = ACT_READ;
      if (shadow_held > 0 && pick < 70) r.log_index = 6'($urandom_range(0, shadow_held - 1));
    end else if (pick < 96) begin
      r.action = ACT_QUERY;
    end else begin
      r.action = ACT_UNUSED;
    end
    return r;
  endfunction

  task automatic offer_request(req_t r, fixed_rsp_t fixed);
    fixed_rsp.push_back(fixed);
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (!(req_if.valid === 1'b1 && req_if.ready === 1'b1));
    @(negedge clk);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // request sender
  initial begin : stimulus
    directed_row_t directed_rows [$];
    fixed_rsp_t    checked;
    int            sent;
    int            burst;
    int            gap;
    bit            drained;
    checked      = '{typed: 1'b0, rsp: NO_RSP};
    sent         = 0;
    drained      = 0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rst_n        = 1'b0;

    directed_rows.push_back(vec(ACT_READ, 4'd0, 16'h0000, 32'h0, 6'd0,
                                1, mk_rsp(0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(vec(ACT_READ, 4'd15, 16'hFFFF, 32'hFFFFFFFF, 6'd63,
                                1, mk_rsp(0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(vec(ACT_QUERY, 4'd0, 16'h0000, 32'h0, 6'd0,
                                1, mk_rsp(1, 0, 0, 0, 0, 0)));
    directed_rows.push_back(vec(ACT_QUERY, 4'd7, 16'h0000, 32'h0, 6'd0,
                                1, mk_rsp(1, 0, 0, 0, 0, 0)));
    directed_rows.push_back(vec(ACT_QUERY, 4'd8, 16'h0000, 32'h0, 6'd0,
                                1, mk_rsp(0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(vec(ACT_QUERY, 4'd15, 16'h0000, 32'h0, 6'd0,
                                1, mk_rsp(0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(vec(ACT_UNUSED, 4'd15, 16'hFFFF, 32'hFFFFFFFF, 6'd63,
                                1, mk_rsp(0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(vec(ACT_EMIT, 4'd0, 16'h8000, 32'h0, 6'd0,
                                1, mk_rsp(0, 0, 0, 0, 1, 1)));
    directed_rows.push_back(vec(ACT_EMIT, 4'd15, 16'h7FFF, 32'hFFFFFFFF, 6'd63,
                                1, mk_rsp(0, 0, 0, 0, 2, 2)));
    directed_rows.push_back(vec(ACT_EMIT, 4'd7, 16'hFFFF, 32'h12345678, 6'd21,
                                1, mk_rsp(0, 0, 0, 0, 3, 3)));
    directed_rows.push_back(vec(ACT_EMIT, 4'd8, 16'h1234, 32'hA5A5A5A5, 6'd42,
                                1, mk_rsp(0, 0, 0, 0, 4, 4)));
    directed_rows.push_back(vec(ACT_READ, 4'd9, 16'h5555, 32'h0, 6'd0,
                                1, mk_rsp(1, 0, 0, 16'h8000, 4, 4)));
    directed_rows.push_back(vec(ACT_READ, 4'd0, 16'h0000, 32'h0, 6'd1,
                                1, mk_rsp(1, 15, 32'hFFFFFFFF, 16'h7FFF, 4, 4)));
    directed_rows.push_back(vec(ACT_READ, 4'd3, 16'hAAAA, 32'h5A5A5A5A, 6'd3, 0, NO_RSP));
    directed_rows.push_back(vec(ACT_READ, 4'd0, 16'h0000, 32'h0, 6'd4,
                                1, mk_rsp(0, 0, 0, 0, 4, 4)));
    directed_rows.push_back(vec(ACT_QUERY, 4'd0, 16'h0000, 32'h0, 6'd0, 0, NO_RSP));
    directed_rows.push_back(vec(ACT_QUERY, 4'd7, 16'hFFFF, 32'hFFFFFFFF, 6'd63, 0, NO_RSP));
    directed_rows.push_back(vec(ACT_QUERY, 4'd8, 16'h0000, 32'h0, 6'd0,
                                1, mk_rsp(0, 0, 0, 0, 4, 4)));
    directed_rows.push_back(vec(ACT_QUERY, 4'd15, 16'h0000, 32'h0, 6'd0, 0, NO_RSP));
    directed_rows.push_back(vec(ACT_EMIT, 4'd3, 16'hC3C3, 32'h80000001, 6'd63, 0, NO_RSP));
    directed_rows.push_back(vec(ACT_READ, 4'd0, 16'h0000, 32'h0, 6'd2, 0, NO_RSP));
    directed_rows.push_back(vec(ACT_UNUSED, 4'd3, 16'h1234, 32'h0F0F0F0F, 6'd1, 0, NO_RSP));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) offer_request(directed_rows[i].req, directed_rows[i].fixed);
    req_if.valid <= 1'b0;
    wait (awaited_rsp.size() == 0);

    // back-to-back requests while the response side is held off
    flood_start = 1'b1;
    @(negedge clk);
    while (sent < RANDOM_ITEMS) begin
      burst = (sent < FLOOD_ITEMS) ? FLOOD_ITEMS : $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        offer_request(random_request(), checked);
        sent++;
      end
      if (sent >= DRAIN_AT && !drained) begin
        drained = 1'b1;
        req_if.valid <= 1'b0;
        wait (awaited_rsp.size() == 0);
        @(negedge clk);
      end else if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    req_if.valid <= 1'b0;
    wait (awaited_rsp.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // response sink with its own stall pattern
  initial begin : response_sink
    rx_mode_e mode;
    int       len;
    int       step;
    rsp_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (flood_start && !hold_done) begin
        hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      len  = $urandom_range(8, 64);
      for (step = 0; step < len && !(flood_start && !hold_done); step++) begin
        case (mode)
          RX_STEADY: rsp_if.ready <= 1'b1;
          RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
          RX_THIRD:  rsp_if.ready <= (step % 3 == 0);
          default:   rsp_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // request/response monitor and watchdog
  always @(posedge clk) begin : monitor
    rsp_t       want;
    rsp_t       got;
    fixed_rsp_t fixed;
    if (rst_n) begin
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        got = rsp_if.data;
        if (awaited_rsp.size() == 0) begin
          $display("%0t: unexpected response, actual %h", $time, got);
          fail_count++;
        end else begin
          want = awaited_rsp.pop_front();
          compare_field("found", 32'(want.found), 32'(got.found));
          compare_field("entry_kind", 32'(want.entry_kind), 32'(got.entry_kind));
          compare_field("out_time", want.out_time, got.out_time);
          compare_field("entry_detail", 32'(want.entry_detail), 32'(got.entry_detail));
          compare_field("emit_total", want.emit_total, got.emit_total);
          compare_field("fill_count", 32'(want.fill_count), 32'(got.fill_count));
        end
      end
      if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
        want  = trace_step(req_if.data);
        fixed = fixed_rsp.pop_front();
        awaited_rsp.push_back(fixed.typed ? fixed.rsp : want);
      end
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request or response for %0d cycles", $time, idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
